### src/assert_macros.svh
// Assertion helpers; clk and arst_n must be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds on every clock edge outside reset
`define IWD_ASSERT(label, prop, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define IWD_ASSERT_NEVER(label, cond, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### src/iwd_pkg.sv
package iwd_pkg;

	localparam int ADC_BITS   = 12;
	localparam int RATE_W     = 12;
	localparam int LEVEL_W    = 14;
	localparam int STEER_W    = 16;
	localparam int ERR_W      = LEVEL_W + 3;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = REG_IDX_W + 2;

	localparam int unsigned SCALE_DIV  = 1000;
	localparam int          FRONT_BIAS = 20;

	// divide by SCALE_DIV as a multiply by a rounded-up reciprocal
	localparam int PROD_W       = ADC_BITS + RATE_W;
	localparam int RECIP_SHIFT  = PROD_W + 10;
	localparam int RECIP_W      = RECIP_SHIFT - 9;
	localparam int SCALED_W     = PROD_W + RECIP_W;
	localparam int QUOT_W       = SCALED_W - RECIP_SHIFT;
	localparam int CMP_W        = (QUOT_W > LEVEL_W) ? QUOT_W : LEVEL_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SCALE_DIV) + 64'd1);

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic signed [ERR_W-1:0] ERR_HI = ERR_W'((1 << (STEER_W - 1)) - 1);
	localparam logic signed [ERR_W-1:0] ERR_LO = -ERR_HI - ERR_W'(1);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RATE,
		REG_FL_THR,
		REG_FR_THR,
		REG_SL_THR,
		REG_SR_THR,
		REG_UPPER_THR,
		REG_LEFT_TGT,
		REG_RIGHT_TGT
	} reg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0]  reflection_rate;
		logic [LEVEL_W-1:0] front_left_threshold;
		logic [LEVEL_W-1:0] front_right_threshold;
		logic [LEVEL_W-1:0] side_left_threshold;
		logic [LEVEL_W-1:0] side_right_threshold;
		logic [LEVEL_W-1:0] upper_front_threshold;
		logic [LEVEL_W-1:0] left_target;
		logic [LEVEL_W-1:0] right_target;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		reflection_rate:       RATE_W'(1000),
		front_left_threshold:  LEVEL_W'(200),
		front_right_threshold: LEVEL_W'(250),
		side_left_threshold:   LEVEL_W'(300),
		side_right_threshold:  LEVEL_W'(500),
		upper_front_threshold: LEVEL_W'(1200),
		left_target:           LEVEL_W'(0),
		right_target:          LEVEL_W'(0)
	};

	typedef struct packed {
		logic [ADC_BITS-1:0] front_left_ambient;
		logic [ADC_BITS-1:0] front_left_lit;
		logic [ADC_BITS-1:0] front_right_ambient;
		logic [ADC_BITS-1:0] front_right_lit;
		logic [ADC_BITS-1:0] diag_left_ambient;
		logic [ADC_BITS-1:0] diag_left_lit;
		logic [ADC_BITS-1:0] diag_right_ambient;
		logic [ADC_BITS-1:0] diag_right_lit;
		logic                hold_steering;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]        front_left_level;
		logic [LEVEL_W-1:0]        front_right_level;
		logic [LEVEL_W-1:0]        diag_left_level;
		logic [LEVEL_W-1:0]        diag_right_level;
		logic                      front_wall;
		logic                      left_wall;
		logic                      right_wall;
		logic signed [STEER_W-1:0] steering_error;
	} out_item_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} pipe_ctrl_t;

endpackage

### src/iwd_cfg_regs.sv
module iwd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [iwd_pkg::PADDR_W-1:0]  paddr,
	input  logic [iwd_pkg::DATA_W-1:0]   pwdata,
	output logic [iwd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output iwd_pkg::cfg_t                cfg
);
	import iwd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_RATE:      cfg_q.reflection_rate       <= pwdata[RATE_W-1:0];
				REG_FL_THR:    cfg_q.front_left_threshold  <= pwdata[LEVEL_W-1:0];
				REG_FR_THR:    cfg_q.front_right_threshold <= pwdata[LEVEL_W-1:0];
				REG_SL_THR:    cfg_q.side_left_threshold   <= pwdata[LEVEL_W-1:0];
				REG_SR_THR:    cfg_q.side_right_threshold  <= pwdata[LEVEL_W-1:0];
				REG_UPPER_THR: cfg_q.upper_front_threshold <= pwdata[LEVEL_W-1:0];
				REG_LEFT_TGT:  cfg_q.left_target           <= pwdata[LEVEL_W-1:0];
				REG_RIGHT_TGT: cfg_q.right_target          <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RATE:      prdata = DATA_W'(cfg_q.reflection_rate);
			REG_FL_THR:    prdata = DATA_W'(cfg_q.front_left_threshold);
			REG_FR_THR:    prdata = DATA_W'(cfg_q.front_right_threshold);
			REG_SL_THR:    prdata = DATA_W'(cfg_q.side_left_threshold);
			REG_SR_THR:    prdata = DATA_W'(cfg_q.side_right_threshold);
			REG_UPPER_THR: prdata = DATA_W'(cfg_q.upper_front_threshold);
			REG_LEFT_TGT:  prdata = DATA_W'(cfg_q.left_target);
			REG_RIGHT_TGT: prdata = DATA_W'(cfg_q.right_target);
			default:       prdata = '0;
		endcase
	end

endmodule

### src/iwd_level_lane.sv
module iwd_level_lane (
	input  logic                          clk,
	input  iwd_pkg::pipe_ctrl_t           ctrl,
	input  logic [iwd_pkg::ADC_BITS-1:0]  ambient,
	input  logic [iwd_pkg::ADC_BITS-1:0]  lit,
	input  logic [iwd_pkg::RATE_W-1:0]    rate,
	output logic [iwd_pkg::LEVEL_W-1:0]   level
);
	import iwd_pkg::*;

	logic [ADC_BITS-1:0] diff;
	logic [PROD_W-1:0]   prod_s2;
	logic [SCALED_W-1:0] scaled;
	logic [CMP_W-1:0]    quot;
	logic [LEVEL_W-1:0]  level_s3;

	// clamp a negative difference to zero
	assign diff   = (lit > ambient) ? (lit - ambient) : '0;
	assign scaled = SCALED_W'(prod_s2) * SCALED_W'(RECIP_MUL);
	assign quot   = CMP_W'(scaled[SCALED_W-1:RECIP_SHIFT]);
	assign level  = level_s3;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			prod_s2 <= PROD_W'(diff) * PROD_W'(rate);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			level_s3 <= (quot > CMP_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];
		end
	end

endmodule

### src/iwd_steer.sv
module iwd_steer (
	input  logic                         clk,
	input  iwd_pkg::pipe_ctrl_t          ctrl,
	input  iwd_pkg::cfg_t                cfg,
	input  logic                         hold,
	input  logic [iwd_pkg::LEVEL_W-1:0]  fl,
	input  logic [iwd_pkg::LEVEL_W-1:0]  fr,
	input  logic [iwd_pkg::LEVEL_W-1:0]  dl,
	input  logic [iwd_pkg::LEVEL_W-1:0]  dr,
	output iwd_pkg::out_item_t           item
);
	import iwd_pkg::*;

	logic                    fwall;
	logic                    lwall;
	logic                    rwall;
	logic                    below;
	logic                    above;
	logic signed [ERR_W-1:0] fl_x;
	logic signed [ERR_W-1:0] fr_x;
	logic signed [ERR_W-1:0] dl_x;
	logic signed [ERR_W-1:0] dr_x;
	logic signed [ERR_W-1:0] lt_x;
	logic signed [ERR_W-1:0] rt_x;
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] err_sat;
	out_item_t               item_q;

	assign fl_x = $signed(ERR_W'(fl));
	assign fr_x = $signed(ERR_W'(fr));
	assign dl_x = $signed(ERR_W'(dl));
	assign dr_x = $signed(ERR_W'(dr));
	assign lt_x = $signed(ERR_W'(cfg.left_target));
	assign rt_x = $signed(ERR_W'(cfg.right_target));

	assign fwall = (fl > cfg.front_left_threshold) && (fr > cfg.front_right_threshold);
	assign lwall = dl > cfg.side_left_threshold;
	assign rwall = dr > cfg.side_right_threshold;
	assign below = (fl < cfg.upper_front_threshold) || (fr < cfg.upper_front_threshold);
	assign above = (fl > cfg.upper_front_threshold) || (fr > cfg.upper_front_threshold);

	always_comb begin
		err = '0;
		if (below && !hold) begin
			if (lwall && rwall) begin
				err = (dr_x - dl_x) - (rt_x - lt_x);
			end else if (lwall) begin
				err = lt_x - dl_x;
			end else if (rwall) begin
				err = dr_x - rt_x;
			end
		end
		// balance on the front pair when close to a front wall
		if (above) begin
			err = fl_x - fr_x + ERR_W'(FRONT_BIAS);
		end
	end

	assign err_sat = (err > ERR_HI) ? ERR_HI : ((err < ERR_LO) ? ERR_LO : err);

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			item_q.front_left_level  <= fl;
			item_q.front_right_level <= fr;
			item_q.diag_left_level   <= dl;
			item_q.diag_right_level  <= dr;
			item_q.front_wall        <= fwall;
			item_q.left_wall         <= lwall;
			item_q.right_wall        <= rwall;
			item_q.steering_error    <= err_sat[STEER_W-1:0];
		end
	end

	assign item = item_q;

endmodule

### src/ir_wall_detect_steering_error_unit.sv
// Infrared wall detection and steering error. Each request carries one sample set of
// four reflectance sensors (ambient and lit readings) plus a hold flag; each yields
// exactly one result with the four scaled levels, the front/left/right wall flags and
// a signed steering error. The block accepts one request per cycle unless stalled from
// the result side. A request lands in the input register, then the gain multiply, the
// divide by 1000 through a reciprocal multiply, and the wall compares with error select
// each take one register stage. Stall on the result side holds the pipeline in place
// and backs up to in_stall. Registers are written over the APB-style port at byte
// address 4*index and should only change while no request is in flight.
module ir_wall_detect_steering_error_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  iwd_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output iwd_pkg::out_item_t           out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [iwd_pkg::PADDR_W-1:0]  paddr,
	input  logic [iwd_pkg::DATA_W-1:0]   pwdata,
	output logic [iwd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import iwd_pkg::*;

	cfg_t               cfg;
	pipe_ctrl_t         ctrl;
	logic               ld_s1;
	in_item_t           item_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               hold_s2;
	logic               hold_s3;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] fl_s3;
	logic [LEVEL_W-1:0] fr_s3;
	logic [LEVEL_W-1:0] dl_s3;
	logic [LEVEL_W-1:0] dr_s3;

	assign ctrl.ld_out = !out_valid_q || !out_stall;
	assign ctrl.ld_s3  = !valid_s3 || ctrl.ld_out;
	assign ctrl.ld_s2  = !valid_s2 || ctrl.ld_s3;
	assign ld_s1       = !valid_s1 || ctrl.ld_s2;
	assign in_stall    = !ld_s1;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= in_valid;
			end
			if (ctrl.ld_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.ld_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ctrl.ld_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= in_item;
		end
		if (ctrl.ld_s2) begin
			hold_s2 <= item_s1.hold_steering;
		end
		if (ctrl.ld_s3) begin
			hold_s3 <= hold_s2;
		end
	end

	iwd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iwd_level_lane u_lane_fl (
		.clk     (clk),
		.ctrl    (ctrl),
		.ambient (item_s1.front_left_ambient),
		.lit     (item_s1.front_left_lit),
		.rate    (cfg.reflection_rate),
		.level   (fl_s3)
	);

	iwd_level_lane u_lane_fr (
		.clk     (clk),
		.ctrl    (ctrl),
		.ambient (item_s1.front_right_ambient),
		.lit     (item_s1.front_right_lit),
		.rate    (cfg.reflection_rate),
		.level   (fr_s3)
	);

	iwd_level_lane u_lane_dl (
		.clk     (clk),
		.ctrl    (ctrl),
		.ambient (item_s1.diag_left_ambient),
		.lit     (item_s1.diag_left_lit),
		.rate    (cfg.reflection_rate),
		.level   (dl_s3)
	);

	iwd_level_lane u_lane_dr (
		.clk     (clk),
		.ctrl    (ctrl),
		.ambient (item_s1.diag_right_ambient),
		.lit     (item_s1.diag_right_lit),
		.rate    (cfg.reflection_rate),
		.level   (dr_s3)
	);

	iwd_steer u_steer (
		.clk  (clk),
		.ctrl (ctrl),
		.cfg  (cfg),
		.hold (hold_s3),
		.fl   (fl_s3),
		.fr   (fr_s3),
		.dl   (dl_s3),
		.dr   (dr_s3),
		.item (out_item)
	);

endmodule

### src/iwd_checker.sv
`include "assert_macros.svh"

module iwd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input iwd_pkg::out_item_t           out_item
);
	import iwd_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	`IWD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed while stalled")
	`IWD_ASSERT(a_no_idle_stall, !out_stall |-> !in_stall, "request stalled without result backpressure")
	`IWD_ASSERT(a_drain, (!in_acc && !out_stall) ##1 (!in_acc && !out_stall) ##1 (!in_acc && !out_stall) ##1 (!in_acc && !out_stall) |=> !out_valid, "result without a request")
	`IWD_ASSERT_NEVER(a_wall_level, out_valid && ((out_item.front_wall && (out_item.front_left_level == '0 || out_item.front_right_level == '0)) || (out_item.left_wall && out_item.diag_left_level == '0) || (out_item.right_wall && out_item.diag_right_level == '0)), "wall flagged on zero level")

endmodule

bind ir_wall_detect_steering_error_unit iwd_checker u_iwd_checker (.*);
